// File: hw/rtl/nearest_circle_tangent_placer_macros.svh
// Assertion macros for the circle placer.
`ifndef NEAREST_CIRCLE_TANGENT_PLACER_MACROS_SVH
`define NEAREST_CIRCLE_TANGENT_PLACER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NCP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NCP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define NCP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/ncp_pkg.sv
package ncp_pkg;

  localparam int CAPACITY  = 1024;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int FRAC_BITS = 4;

  localparam int POS_W    = 20;
  localparam int PIX_W    = 12;
  localparam int RAD_W    = 8;
  localparam int IDX_W    = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;

  localparam int PX_W  = PIX_W + FRAC_BITS;
  localparam int LEN_W = RAD_W + 1 + FRAC_BITS;
  localparam int AD_W  = (((POS_W - 1) > PX_W) ? (POS_W - 1) : PX_W) + 1;
  localparam int DX_W  = AD_W + 1;
  localparam int D2_W  = 2 * AD_W + 1;
  localparam int D2H_W = (D2_W + 1) / 2;
  localparam int Q_W   = LEN_W + 1;
  localparam int Q2_W  = 2 * Q_W;
  localparam int P_W   = LEN_W + AD_W + 1;
  localparam int PH_W  = (P_W + 1) / 2;
  localparam int MA_W  = Q2_W;
  localparam int MB_T  = (D2H_W > AD_W) ? D2H_W : AD_W;
  localparam int MB_W  = (MB_T > PH_W) ? MB_T : PH_W;
  localparam int MP_W  = MA_W + MB_W;
  localparam int CW    = Q2_W + D2_W;
  localparam int BIT_W = $clog2(LEN_W);

  localparam logic signed [POS_W+1:0] POS_MAX = (POS_W+2)'(2**(POS_W-1) - 1);
  localparam logic signed [POS_W+1:0] POS_MIN = -(POS_W+2)'(2**(POS_W-1));

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED = 2'd0,
    ST_FULL   = 2'd1,
    ST_ORDER  = 2'd2
  } status_t;

  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_GROW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CIRCLES = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic [RAD_W-1:0]        r;
  } entry_t;

  typedef struct packed {
    status_t                 status;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [RAD_W-1:0]        r;
    logic [IDX_W-1:0]        nb;
    logic [COUNT_W-1:0]      count;
  } result_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    if (v > POS_MAX) begin
      return POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      return POS_MIN[POS_W-1:0];
    end
    return v[POS_W-1:0];
  endfunction

endpackage

// File: hw/rtl/ncp_channels.sv
interface ncp_item_if import ncp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [PIX_W-1:0]     cand_x;
  logic [PIX_W-1:0]     cand_y;
  logic [RAD_W-1:0]     cand_radius;
  modport source (output valid, kind, cand_x, cand_y, cand_radius, input ready);
  modport sink (input valid, kind, cand_x, cand_y, cand_radius, output ready);
endinterface

interface ncp_result_if import ncp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [POS_W-1:0] placed_x;
  logic signed [POS_W-1:0] placed_y;
  logic [RAD_W-1:0]        placed_radius;
  logic [IDX_W-1:0]        neighbour_index;
  logic [COUNT_W-1:0]      circle_count;
  modport source (output valid, status, placed_x, placed_y, placed_radius,
                  neighbour_index, circle_count, input ready);
  modport sink (input valid, status, placed_x, placed_y, placed_radius,
                neighbour_index, circle_count, output ready);
endinterface

interface ncp_cfg_if import ncp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ncp_mul2.sv
// two-lane shared multiplier, registered products
module ncp_mul2 import ncp_pkg::*; (
  input  logic            clk,
  input  logic [MA_W-1:0] a0,
  input  logic [MB_W-1:0] b0,
  input  logic [MA_W-1:0] a1,
  input  logic [MB_W-1:0] b1,
  output logic [MP_W-1:0] p0,
  output logic [MP_W-1:0] p1
);

  always_ff @(posedge clk) begin
    p0 <= MP_W'(a0) * MP_W'(b0);
    p1 <= MP_W'(a1) * MP_W'(b1);
  end

endmodule

// File: hw/rtl/ncp_store.sv
module ncp_store import ncp_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/nearest_circle_tangent_placer.sv
// Every result passes from a pending register to the output register once that is free or
// being read. A grow request first scans the N stored circles, one stored circle a cycle,
// then runs two 13-step offset searches on the shared two-lane multiplier.
// One request at a time; not ready again until the result is registered.
// A finished result waits in an output register while the next request is taken.
// Reset: circle count zero, seed_radius 10, max_circles 1024; store contents undefined.
`include "nearest_circle_tangent_placer_macros.svh"

module nearest_circle_tangent_placer import ncp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ncp_item_if.sink      item,
  ncp_result_if.source  result,
  ncp_cfg_if.sink       cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PREP, S_LENAD, S_PSQ1, S_PSQ2, S_PSQ3,
    S_TSQ, S_TMUL, S_TCMP, S_PLACE, S_FIN
  } state_t;

  state_t state;

  logic [RAD_W-1:0]   seed_radius;
  logic [COUNT_W-1:0] max_circles;
  logic [CNT_W-1:0]   count;
  logic [PX_W-1:0]    px, py;
  logic [RAD_W-1:0]   cr;

  logic [CNT_W-1:0]  issue;
  logic              s1_v, s2_v;
  logic [ADDR_W-1:0] s1_idx, s2_idx;
  entry_t            s2_e;
  logic [D2_W-1:0]   best;
  logic [ADDR_W-1:0] bi;
  entry_t            be;

  logic [AD_W-1:0]  adx, ady;
  logic             sx, sy;
  logic [LEN_W-1:0] len;
  logic             ax;
  logic [P_W-1:0]   preg;
  logic [MP_W-1:0]  rhh, rhl;
  logic [CW-1:0]    rr;
  logic [BIT_W-1:0] b;
  logic [LEN_W-1:0] m, treg;
  logic [LEN_W-1:0] offx, offy;

  result_t pend, out;
  logic    out_v;

  entry_t            rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;
  logic [MA_W-1:0]   a0, a1;
  logic [MB_W-1:0]   b0, b1;
  logic [MP_W-1:0]   p0, p1;

  logic signed [DX_W-1:0] dx1, dy1, dxp, dyp;
  logic [AD_W-1:0]        adx1, ady1;
  logic [D2_W-1:0]        e2;
  logic                   issuing;
  logic [CNT_W-1:0]       limit;
  logic [LEN_W-1:0]       len_c, tcur, m_new;
  logic [Q_W-1:0]         q_c;
  logic [AD_W-1:0]        ad_sel;
  logic [P_W-1:0]         p_c;
  logic [CW-1:0]          lhs;
  logic signed [POS_W+1:0] nx_w, ny_w;
  logic signed [POS_W-1:0] nx, ny;
  logic                   accept;

  ncp_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (issue[ADDR_W-1:0]),
    .rdata (rdata)
  );

  ncp_mul2 u_mul (
    .clk (clk),
    .a0  (a0),
    .b0  (b0),
    .a1  (a1),
    .b1  (b1),
    .p0  (p0),
    .p1  (p1)
  );

  assign accept = item.valid && item.ready;
  assign limit  = (max_circles > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(max_circles);
  assign issuing = (state == S_SCAN) && (issue < count);

  always_comb begin
    dx1  = $signed({{(DX_W-PX_W){1'b0}}, px}) - $signed({{(DX_W-POS_W){rdata.cx[POS_W-1]}}, rdata.cx});
    dy1  = $signed({{(DX_W-PX_W){1'b0}}, py}) - $signed({{(DX_W-POS_W){rdata.cy[POS_W-1]}}, rdata.cy});
    adx1 = dx1[DX_W-1] ? AD_W'(-dx1) : AD_W'(dx1);
    ady1 = dy1[DX_W-1] ? AD_W'(-dy1) : AD_W'(dy1);
    dxp  = $signed({{(DX_W-PX_W){1'b0}}, px}) - $signed({{(DX_W-POS_W){be.cx[POS_W-1]}}, be.cx});
    dyp  = $signed({{(DX_W-PX_W){1'b0}}, py}) - $signed({{(DX_W-POS_W){be.cy[POS_W-1]}}, be.cy});
    e2   = D2_W'(p0) + D2_W'(p1);
    len_c = LEN_W'({1'b0, cr} + {1'b0, be.r}) << FRAC_BITS;
    tcur  = m | (LEN_W'(1) << b);
    q_c   = {tcur, 1'b0} - Q_W'(1);
    ad_sel = ax ? ady : adx;
    p_c   = {p0[P_W-2:0], 1'b0};
    lhs   = (CW'(p1) << D2H_W) + CW'(p0);
    m_new = (lhs <= rr) ? treg : m;
    nx_w  = (POS_W+2)'(be.cx) + (sx ? -(POS_W+2)'(offx) : (POS_W+2)'(offx));
    ny_w  = (POS_W+2)'(be.cy) + (sy ? -(POS_W+2)'(offy) : (POS_W+2)'(offy));
    nx    = sat_pos(nx_w);
    ny    = sat_pos(ny_w);
  end

  always_comb begin
    a0 = '0;
    b0 = '0;
    a1 = '0;
    b1 = '0;
    case (state)
      S_SCAN: begin
        a0 = MA_W'(adx1);
        b0 = MB_W'(adx1);
        a1 = MA_W'(ady1);
        b1 = MB_W'(ady1);
      end
      S_LENAD: begin
        a0 = MA_W'(len);
        b0 = MB_W'(ad_sel);
      end
      S_PSQ1: begin
        a0 = MA_W'(p_c[P_W-1:PH_W]);
        b0 = MB_W'(p_c[P_W-1:PH_W]);
        a1 = MA_W'(p_c[P_W-1:PH_W]);
        b1 = MB_W'(p_c[PH_W-1:0]);
      end
      S_PSQ2: begin
        a0 = MA_W'(preg[PH_W-1:0]);
        b0 = MB_W'(preg[PH_W-1:0]);
      end
      S_TSQ: begin
        a0 = MA_W'(q_c);
        b0 = MB_W'(q_c);
      end
      S_TMUL: begin
        a0 = p0[MA_W-1:0];
        b0 = MB_W'(best[D2H_W-1:0]);
        a1 = p0[MA_W-1:0];
        b1 = MB_W'(best >> D2H_W);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[ADDR_W-1:0];
    wdata = '{cx: nx, cy: ny, r: cr};
    if (state == S_IDLE) begin
      we    = accept && (item.kind == KIND_SEED) && (count == '0);
      waddr = '0;
      wdata = '{cx: POS_W'(item.cand_x) << FRAC_BITS, cy: POS_W'(item.cand_y) << FRAC_BITS,
                r: seed_radius};
    end else if (state == S_PLACE) begin
      we = 1'b1;
    end
  end

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid           = out_v;
  assign result.status          = out.status;
  assign result.placed_x        = out.x;
  assign result.placed_y        = out.y;
  assign result.placed_radius   = out.r;
  assign result.neighbour_index = out.nb;
  assign result.circle_count    = out.count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seed_radius <= RAD_W'(10);
      max_circles <= COUNT_W'(CAPACITY);
      count       <= '0;
      out_v       <= 1'b0;
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_SEED_RADIUS: seed_radius <= cfg.data[RAD_W-1:0];
          CFG_MAX_CIRCLES: max_circles <= cfg.data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_v && result.ready && (state != S_FIN)) begin
        out_v <= 1'b0;
      end
      s1_v   <= issuing;
      s1_idx <= issue[ADDR_W-1:0];
      s2_v   <= s1_v;
      s2_idx <= s1_idx;
      s2_e   <= rdata;
      case (state)
        S_IDLE: begin
          if (accept) begin
            px   <= PX_W'(item.cand_x) << FRAC_BITS;
            py   <= PX_W'(item.cand_y) << FRAC_BITS;
            cr   <= item.cand_radius;
            if ((item.kind == KIND_SEED) && (count == '0)) begin
              count <= CNT_W'(1);
              pend  <= '{status: ST_STORED,
                         x: POS_W'(item.cand_x) << FRAC_BITS,
                         y: POS_W'(item.cand_y) << FRAC_BITS,
                         r: seed_radius, nb: '0, count: COUNT_W'(1)};
              state <= S_FIN;
            end else if ((item.kind == KIND_GROW) && (count != '0) && (count < limit)) begin
              issue <= '0;
              best  <= '1;
              bi    <= '0;
              state <= S_SCAN;
            end else begin
              pend  <= '{status: ((item.kind == KIND_GROW) && (count != '0)) ? ST_FULL
                                                                             : ST_ORDER,
                         x: '0, y: '0, r: '0, nb: '0, count: COUNT_W'(count)};
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issue <= issue + CNT_W'(1);
          end
          if (s2_v && (e2 < best)) begin
            best <= e2;
            bi   <= s2_idx;
            be   <= s2_e;
          end
          if (!issuing && !s1_v && !s2_v) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          len <= len_c;
          ax  <= 1'b0;
          if (best == '0) begin
            offx  <= len_c;
            offy  <= '0;
            sx    <= 1'b0;
            sy    <= 1'b0;
            state <= S_PLACE;
          end else begin
            adx   <= dxp[DX_W-1] ? AD_W'(-dxp) : AD_W'(dxp);
            ady   <= dyp[DX_W-1] ? AD_W'(-dyp) : AD_W'(dyp);
            sx    <= dxp[DX_W-1];
            sy    <= dyp[DX_W-1];
            state <= S_LENAD;
          end
        end
        S_LENAD: state <= S_PSQ1;
        S_PSQ1: begin
          preg  <= p_c;
          state <= S_PSQ2;
        end
        S_PSQ2: begin
          rhh   <= p0;
          rhl   <= p1;
          state <= S_PSQ3;
        end
        S_PSQ3: begin
          rr    <= (CW'(rhh) << (2 * PH_W)) + (CW'(rhl) << (PH_W + 1)) + CW'(p0);
          b     <= BIT_W'(LEN_W - 1);
          m     <= '0;
          state <= S_TSQ;
        end
        S_TSQ: begin
          treg <= tcur;
          if (tcur <= len) begin
            state <= S_TMUL;
          end else if (b == '0) begin
            if (ax) begin
              offy  <= m;
              state <= S_PLACE;
            end else begin
              offx  <= m;
              ax    <= 1'b1;
              state <= S_LENAD;
            end
          end else begin
            b <= b - BIT_W'(1);
          end
        end
        S_TMUL: state <= S_TCMP;
        S_TCMP: begin
          m <= m_new;
          if (b == '0) begin
            if (ax) begin
              offy  <= m_new;
              state <= S_PLACE;
            end else begin
              offx  <= m_new;
              ax    <= 1'b1;
              state <= S_LENAD;
            end
          end else begin
            b     <= b - BIT_W'(1);
            state <= S_TSQ;
          end
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          pend  <= '{status: ST_STORED, x: nx, y: ny, r: cr, nb: IDX_W'(bi),
                     count: COUNT_W'(count + CNT_W'(1))};
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_v || result.ready) begin
            out   <= pend;
            out_v <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NCP_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `NCP_ASSERT_IMP(a_scan_addr, clk, rst, issuing, issue < count, "scan past stored circles")
  `NCP_ASSERT_IMP(a_off_len, clk, rst, state == S_TCMP, m <= len, "offset above tangent length")
  `NCP_ASSERT_NXT(a_place_count, clk, rst, state == S_PLACE, count == $past(count) + CNT_W'(1),
                  "append did not advance count")

endmodule

// File: tb/tb_top.sv
module tb_top;
  import ncp_pkg::*;

  typedef struct {
    status_t                 status;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [RAD_W-1:0]        r;
    logic [IDX_W-1:0]        nb;
    logic [COUNT_W-1:0]      count;
  } placement_t;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;

  ncp_item_if   item_ch();
  ncp_result_if result_ch();
  ncp_cfg_if    cfg_ch();

  nearest_circle_tangent_placer i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // own copy of the circle store and registers
  int          circ_x [CAPACITY];
  int          circ_y [CAPACITY];
  int          circ_r [CAPACITY];
  int          circ_count;
  int          seed_rad_reg;
  int          max_circ_reg;

  placement_t  pending_placements[$];
  int          fail_count;
  int          sent_count;
  int          n_stored;
  int          n_full;
  int          n_order;
  int          idle_cycles;
  bit          calm;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int clamp_pos(longint v);
    if (v > 524287) begin
      return 524287;
    end
    if (v < -524288) begin
      return -524288;
    end
    return int'(v);
  endfunction

  // round(len * ad / sqrt(d2)), exact, ties upwards
  function automatic longint tangent_offset(longint len, longint ad, longint d2);
    logic [127:0] rhs;
    logic [127:0] lhs;
    longint       lo;
    longint       hi;
    longint       mid;
    longint       q;
    rhs = 128'(2 * len * ad);
    rhs = rhs * rhs;
    lo = 0;
    hi = len;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      q = 2 * mid - 1;
      lhs = 128'(q * q) * 128'(d2);
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  function automatic placement_t place_circle(logic kind, int cx, int cy, int cr);
    placement_t p;
    longint     px;
    longint     py;
    longint     ex;
    longint     ey;
    longint     e2;
    longint     best;
    longint     dx;
    longint     dy;
    longint     adx;
    longint     ady;
    longint     d2;
    longint     len;
    longint     nx;
    longint     ny;
    longint     offx;
    longint     offy;
    int         limit;
    int         bi;
    p.status = ST_STORED;
    p.x = '0;
    p.y = '0;
    p.r = '0;
    p.nb = '0;
    px = longint'(cx) << FRAC_BITS;
    py = longint'(cy) << FRAC_BITS;
    limit = (max_circ_reg < CAPACITY) ? max_circ_reg : CAPACITY;
    if (kind == KIND_SEED) begin
      if (circ_count != 0) begin
        p.status = ST_ORDER;
      end else begin
        circ_x[0] = clamp_pos(px);
        circ_y[0] = clamp_pos(py);
        circ_r[0] = seed_rad_reg;
        circ_count = 1;
        p.x = POS_W'(circ_x[0]);
        p.y = POS_W'(circ_y[0]);
        p.r = RAD_W'(seed_rad_reg);
      end
    end else if (circ_count == 0) begin
      p.status = ST_ORDER;
    end else if (circ_count >= limit) begin
      p.status = ST_FULL;
    end else begin
      best = 64'h7fff_ffff_ffff_ffff;
      bi = 0;
      for (int i = 0; i < circ_count; i++) begin
        ex = px - circ_x[i];
        ey = py - circ_y[i];
        e2 = ex * ex + ey * ey;
        if (e2 < best) begin
          best = e2;
          bi = i;
        end
      end
      dx = px - circ_x[bi];
      dy = py - circ_y[bi];
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      d2 = adx * adx + ady * ady;
      len = longint'(cr + circ_r[bi]) << FRAC_BITS;
      if (d2 == 0) begin
        nx = circ_x[bi] + len;
        ny = circ_y[bi];
      end else begin
        offx = tangent_offset(len, adx, d2);
        offy = tangent_offset(len, ady, d2);
        nx = circ_x[bi] + ((dx < 0) ? -offx : offx);
        ny = circ_y[bi] + ((dy < 0) ? -offy : offy);
      end
      circ_x[circ_count] = clamp_pos(nx);
      circ_y[circ_count] = clamp_pos(ny);
      circ_r[circ_count] = cr;
      p.x = POS_W'(circ_x[circ_count]);
      p.y = POS_W'(circ_y[circ_count]);
      p.r = RAD_W'(cr);
      p.nb = IDX_W'(bi);
      circ_count++;
    end
    p.count = COUNT_W'(circ_count);
    return p;
  endfunction

  task automatic send_request(logic kind, int cx, int cy, int cr);
    placement_t exp_p;
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= kind;
    item_ch.cand_x      <= PIX_W'(cx);
    item_ch.cand_y      <= PIX_W'(cy);
    item_ch.cand_radius <= RAD_W'(cr);
    do begin
      @(posedge clk);
    end while (!item_ch.ready);
    exp_p = place_circle(kind, cx, cy, cr);
    pending_placements.insert(pending_placements.size(), exp_p);
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_placements.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DAT_W'(value);
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    if (idx == CFG_SEED_RADIUS) begin
      seed_rad_reg = value & 8'hff;
    end else begin
      max_circ_reg = value & 11'h7ff;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_grow();
    int cx;
    int cy;
    int cr;
    int k;
    if (circ_count != 0 && $urandom_range(0, 1) == 0) begin
      k = $urandom_range(0, circ_count - 1);
      cx = (circ_x[k] >>> FRAC_BITS) + $urandom_range(0, 40) - 20;
      cy = (circ_y[k] >>> FRAC_BITS) + $urandom_range(0, 40) - 20;
      cx = (cx < 0) ? 0 : ((cx > 4095) ? 4095 : cx);
      cy = (cy < 0) ? 0 : ((cy > 4095) ? 4095 : cy);
    end else begin
      cx = $urandom_range(0, 4095);
      cy = $urandom_range(0, 4095);
    end
    cr = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
    send_request(($urandom_range(0, 19) == 0) ? KIND_SEED : KIND_GROW, cx, cy, cr);
  endtask

  task automatic test_order_rules();
    send_request(KIND_GROW, 100, 100, 20);
    send_request(KIND_GROW, 4095, 4095, 255);
  endtask

  task automatic test_seed_and_limits();
    wait_drained();
    write_reg(CFG_SEED_RADIUS, 0);
    write_reg(CFG_SEED_RADIUS, 255);
    case ($urandom_range(0, 2))
      0: write_reg(CFG_SEED_RADIUS, 0);
      1: write_reg(CFG_SEED_RADIUS, 255);
      default: write_reg(CFG_SEED_RADIUS, $urandom_range(1, 254));
    endcase
    write_reg(CFG_MAX_CIRCLES, 0);
    send_request(KIND_SEED, 2000, 2000, 0);
    send_request(KIND_SEED, 0, 0, 1);
    send_request(KIND_GROW, 2100, 2000, 40);
    wait_drained();
    write_reg(CFG_MAX_CIRCLES, 1);
    send_request(KIND_GROW, 2100, 2000, 40);
    wait_drained();
    write_reg(CFG_MAX_CIRCLES, 2047);
  endtask

  task automatic test_tangent_cases();
    send_request(KIND_GROW, 2100, 2000, 40);
    // at the midpoint of the first two centres, rounded down: lowest index must win
    send_request(KIND_GROW, 2000 + (circ_x[1] - circ_x[0]) / 32, 2000, 7);
    send_request(KIND_GROW, 2000, 2000, 255);
    send_request(KIND_GROW, 2000, 3000, 1);
    send_request(KIND_GROW, 0, 0, 1);
    send_request(KIND_GROW, 4095, 4095, 255);
    send_request(KIND_GROW, 4095, 0, 128);
    send_request(KIND_GROW, 0, 4095, 0);
    send_request(KIND_GROW, 2731, 1365, 85);
    send_request(KIND_GROW, 1365, 2730, 170);
    send_request(KIND_GROW, circ_x[2] >>> FRAC_BITS, circ_y[2] >>> FRAC_BITS, 255);
    send_request(KIND_SEED, 4095, 4095, 255);
  endtask

  task automatic test_random_growth();
    int phase_len;
    while (sent_count < 460) begin
      wait_drained();
      case ($urandom_range(0, 4))
        0: write_reg(CFG_MAX_CIRCLES, circ_count + $urandom_range(0, 10));
        1: write_reg(CFG_MAX_CIRCLES, 1024);
        2: write_reg(CFG_MAX_CIRCLES, 2047);
        3: write_reg(CFG_MAX_CIRCLES, $urandom_range(0, 2047));
        default: write_reg(CFG_SEED_RADIUS, $urandom_range(0, 255));
      endcase
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) send_random_grow();
    end
  endtask

  task automatic test_back_to_back();
    wait_drained();
    write_reg(CFG_MAX_CIRCLES, 1024);
    calm = 1'b1;
    repeat (60) send_random_grow();
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.kind = KIND_SEED;
    item_ch.cand_x = '0;
    item_ch.cand_y = '0;
    item_ch.cand_radius = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SEED_RADIUS;
    cfg_ch.data = '0;
    circ_count = 0;
    seed_rad_reg = 10;
    max_circ_reg = 1024;
    fail_count = 0;
    sent_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_order_rules();
    test_seed_and_limits();
    test_tangent_cases();
    test_random_growth();
    test_back_to_back();

    wait_drained();
    repeat (200) @(posedge clk);
    $display("%0d requests: %0d stored, %0d store full, %0d out of order; %0d circles held",
             sent_count, n_stored, n_full, n_order, circ_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    result_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    placement_t exp_p;
    if (!rst) begin
      if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (result_ch.valid && result_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_placements.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp_p = pending_placements.pop_front();
          case (exp_p.status)
            ST_STORED: n_stored++;
            ST_FULL:   n_full++;
            default:   n_order++;
          endcase
          if (result_ch.status !== exp_p.status) begin
            $error("status exp %0d got %0d", exp_p.status, result_ch.status);
            fail_count++;
          end
          if (result_ch.placed_x !== exp_p.x) begin
            $error("placed_x exp %0d got %0d", exp_p.x, result_ch.placed_x);
            fail_count++;
          end
          if (result_ch.placed_y !== exp_p.y) begin
            $error("placed_y exp %0d got %0d", exp_p.y, result_ch.placed_y);
            fail_count++;
          end
          if (result_ch.placed_radius !== exp_p.r) begin
            $error("placed_radius exp %0d got %0d", exp_p.r, result_ch.placed_radius);
            fail_count++;
          end
          if (result_ch.neighbour_index !== exp_p.nb) begin
            $error("neighbour_index exp %0d got %0d", exp_p.nb, result_ch.neighbour_index);
            fail_count++;
          end
          if (result_ch.circle_count !== exp_p.count) begin
            $error("circle_count exp %0d got %0d", exp_p.count, result_ch.circle_count);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
      n_stored <= 0;
      n_full <= 0;
      n_order <= 0;
    end
  end

endmodule
